FILE: rtl/i2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_pkg: shared types and tables for the integer to Roman numeral converter
// Decimal step thresholds, numeral letters per digit position, queue entry
// and controller state types.
// ----------------------------------------------------------------------------
package i2r_pkg;

	localparam int ValueW  = 12;
	localparam int SymbolW = 8;
	localparam int DigitW  = 4;
	localparam int NumDigits = 4;
	localparam int ThreshW = 14;

	localparam logic [ValueW-1:0] TopValue = 12'd3999;

	// Index of the digit slot: 0 thousands, 1 hundreds, 2 tens, 3 ones
	typedef logic [1:0] pos_t;
	typedef logic [DigitW-1:0] digit_t;

	localparam pos_t PosThousands = 2'd0;
	localparam pos_t PosTens      = 2'd2;
	localparam pos_t PosOnes      = 2'd3;

	localparam logic [SymbolW-1:0] SymNone = 8'd0;

	// k times the weight of the thousands, hundreds and tens steps, k = 0..9
	localparam logic [ThreshW-1:0] THRESH [0:2][0:9] = '{
		'{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
		  14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000},
		'{14'd0, 14'd100, 14'd200, 14'd300, 14'd400,
		  14'd500, 14'd600, 14'd700, 14'd800, 14'd900},
		'{14'd0, 14'd10, 14'd20, 14'd30, 14'd40,
		  14'd50, 14'd60, 14'd70, 14'd80, 14'd90}
	};

	// Unit, five and ten letters for each digit position
	localparam logic [SymbolW-1:0] ONE_CH  [0:3] = '{8'h4D, 8'h43, 8'h58, 8'h49};
	localparam logic [SymbolW-1:0] FIVE_CH [0:3] = '{8'h00, 8'h44, 8'h4C, 8'h56};
	localparam logic [SymbolW-1:0] TEN_CH  [0:3] = '{8'h00, 8'h4D, 8'h43, 8'h58};

	typedef struct packed {
		logic                           invalid;
		logic [NumDigits-1:0][DigitW-1:0] digits;
	} entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SPLIT,
		F_PUSH
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_RUN
	} back_state_t;

	// Number of letters a decimal digit takes
	function automatic logic [2:0] run_len(input digit_t d);
		logic [2:0] n;
		unique case (d)
			4'd0: n = 3'd0;
			4'd1, 4'd5: n = 3'd1;
			4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
			4'd3, 4'd7: n = 3'd3;
			4'd8: n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Letter j of digit d at position p
	function automatic logic [SymbolW-1:0] glyph(input pos_t p, input digit_t d,
		input logic [1:0] j);
		logic [SymbolW-1:0] ch;
		unique case (d)
			4'd1, 4'd2, 4'd3: ch = ONE_CH[p];
			4'd4: ch = (j == 2'd0) ? ONE_CH[p] : FIVE_CH[p];
			4'd5: ch = FIVE_CH[p];
			4'd6, 4'd7, 4'd8: ch = (j == 2'd0) ? FIVE_CH[p] : ONE_CH[p];
			4'd9: ch = (j == 2'd0) ? ONE_CH[p] : TEN_CH[p];
			default: ch = SymNone;
		endcase
		return ch;
	endfunction

endpackage

FILE: rtl/i2r_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_if: channel interfaces of the Roman numeral converter
// Value channel in, character channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2r_value_if;
	import i2r_pkg::*;

	logic              valid;
	logic              ready;
	logic [ValueW-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface i2r_char_if;
	import i2r_pkg::*;

	logic               valid;
	logic               ready;
	logic [SymbolW-1:0] symbol;
	logic               last;
	logic               invalid;

	modport source(output valid, output symbol, output last, output invalid, input ready);
	modport sink(input valid, input symbol, input last, input invalid, output ready);
endinterface

FILE: rtl/i2r_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_front: input stage of the Roman numeral converter
// Range-checks each value, splits one in range into decimal digits, one
// digit a cycle with tens and ones together, then hands the entry to the queue.
// ----------------------------------------------------------------------------
module i2r_front (
	input  logic            clk,
	input  logic            arst_n,
	i2r_value_if.sink       num,
	output logic            push,
	output i2r_pkg::entry_t push_entry,
	input  logic            full
);
	import i2r_pkg::*;

	front_state_t      state_q, state_d;
	logic [ValueW-1:0] rem_q;
	logic [1:0]        step_q;
	entry_t            entry_q;

	logic              take;
	logic              bad_c;
	digit_t            digit_c;
	logic [ThreshW-1:0] rem_ext;
	logic [ThreshW-1:0] rem_next;

	assign take  = num.valid && num.ready;
	assign bad_c = (num.value == '0) || (num.value > TopValue);

	// Find the digit of the current step: largest k with k*weight <= remainder
	always_comb begin
		rem_ext = {{(ThreshW-ValueW){1'b0}}, rem_q};
		digit_c = '0;
		for (int k = 1; k < 10; k++) begin
			if (rem_ext >= THRESH[step_q][k]) begin
				digit_c = DigitW'(k);
			end
		end
		rem_next = rem_ext - THRESH[step_q][digit_c];
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d    = state_q;
		num.ready  = 1'b0;
		push       = 1'b0;
		push_entry = entry_q;
		unique case (state_q)
			F_IDLE: begin
				num.ready = 1'b1;
				if (num.valid) begin
					state_d = bad_c ? F_PUSH : F_SPLIT;
				end
			end
			F_SPLIT: begin
				if (step_q == PosTens) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Load the value, then peel off one digit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= PosThousands;
		end else if (take) begin
			step_q <= PosThousands;
		end else if (state_q == F_SPLIT) begin
			step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_q           <= num.value;
			entry_q.invalid <= bad_c;
			entry_q.digits  <= '0;
		end else if (state_q == F_SPLIT) begin
			rem_q                  <= rem_next[ValueW-1:0];
			entry_q.digits[step_q] <= digit_c;
			if (step_q == PosTens) begin
				entry_q.digits[PosOnes] <= rem_next[DigitW-1:0];
			end
		end
	end

endmodule

FILE: rtl/i2r_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_queue: two-entry queue between the front and back stages
// Holds split values so that digit extraction runs ahead of emission.
// ----------------------------------------------------------------------------
module i2r_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2r_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output i2r_pkg::entry_t pop_entry,
	output logic            empty
);
	import i2r_pkg::*;

	entry_t     slot_q [0:1];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign empty     = (count_q == 2'd0);
	assign pop_entry = slot_q[rd_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

endmodule

FILE: rtl/i2r_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_back: emission stage of the Roman numeral converter
// Walks the nonzero digits of a queued entry and emits one numeral letter
// per cycle into an output register while the output is not stalled.
// ----------------------------------------------------------------------------
module i2r_back (
	input  logic            clk,
	input  logic            arst_n,
	output logic            pop,
	input  i2r_pkg::entry_t pop_entry,
	input  logic            empty,
	i2r_char_if.source      chars
);
	import i2r_pkg::*;

	back_state_t  state_q, state_d;
	entry_t       cur_q;
	pos_t         pos_q;
	logic [1:0]   idx_q;

	logic               out_valid_q;
	logic [SymbolW-1:0] out_symbol_q;
	logic               out_last_q;
	logic               out_invalid_q;

	logic               adv;
	digit_t             dig_c;
	logic               more_c;
	pos_t               next_pos_c;
	pos_t               first_pos_c;
	logic               digit_end_c;
	logic               last_c;
	logic [SymbolW-1:0] sym_c;

	assign adv = !out_valid_q || chars.ready;

	// First nonzero digit of the incoming entry
	always_comb begin
		first_pos_c = PosOnes;
		for (int p = NumDigits - 1; p >= 0; p--) begin
			if (pop_entry.digits[p] != '0) begin
				first_pos_c = pos_t'(p);
			end
		end
	end

	// Next nonzero digit after the current one, and the letter to emit now
	always_comb begin
		dig_c      = cur_q.digits[pos_q];
		more_c     = 1'b0;
		next_pos_c = pos_q;
		for (int p = NumDigits - 1; p >= 0; p--) begin
			if ((pos_t'(p) > pos_q) && (cur_q.digits[p] != '0)) begin
				more_c     = 1'b1;
				next_pos_c = pos_t'(p);
			end
		end
		digit_end_c = ({1'b0, idx_q} == run_len(dig_c) - 3'd1);
		last_c      = cur_q.invalid || (digit_end_c && !more_c);
		sym_c       = cur_q.invalid ? SymNone : glyph(pos_q, dig_c, idx_q);
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and queue pop
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = B_RUN;
				end
			end
			B_RUN: begin
				if (adv && last_c) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Load an entry and step through its letters
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_entry;
			pos_q <= first_pos_c;
			idx_q <= 2'd0;
		end else if (state_q == B_RUN && adv) begin
			if (digit_end_c) begin
				pos_q <= next_pos_c;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Output register: fill on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == B_RUN && adv) begin
			out_valid_q <= 1'b1;
		end else if (chars.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_RUN && adv) begin
			out_symbol_q  <= sym_c;
			out_last_q    <= last_c;
			out_invalid_q <= cur_q.invalid;
		end
	end

	assign chars.valid   = out_valid_q;
	assign chars.symbol  = out_symbol_q;
	assign chars.last    = out_last_q;
	assign chars.invalid = out_invalid_q;

endmodule

FILE: rtl/integer_to_roman_numeral.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_roman_numeral: binary value to Roman numeral character stream
//
//   channel | dir | fields                      | transaction
//   num     | in  | value[11:0]                 | one number to convert
//   chars   | out | symbol[7:0], last, invalid  | one numeral letter
//
// The front accepts a value, takes three compare steps and hands it off;
// a value out of range skips the compare steps. The back loads an entry,
// then emits one letter per cycle while the output is not stalled. The
// slower of the two sides sets the rate at which values pass through.
// A value of 0 or above 3999 yields one letter 0 with last and invalid set.
// Output stalls hold the back; the two-entry queue lets the front run ahead.
// Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral (
	input  logic       clk,
	input  logic       arst_n,
	i2r_value_if.sink  num,
	i2r_char_if.source chars
);
	import i2r_pkg::*;

	logic   push;
	logic   pop;
	logic   full;
	logic   empty;
	entry_t push_entry;
	entry_t pop_entry;

	// Range check and digit split
	i2r_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.num        (num),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	// Decouple split from emission
	i2r_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (empty)
	);

	// Letter emission
	i2r_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_entry (pop_entry),
		.empty     (empty),
		.chars     (chars)
	);

endmodule

FILE: sim/roman_letter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_letter_checker: predicts and checks the letters of each Roman numeral
// Watches both channels of the converter. Every accepted value is expanded
// into its expected letter run; every accepted letter is compared, field by
// field, against the oldest letter still expected.
// ----------------------------------------------------------------------------
module roman_letter_checker (
	input  logic clk,
	input  logic arst_n,
	i2r_value_if num,
	i2r_char_if  chars,
	output int   mismatches,
	output int   outstanding,
	output int   values_seen,
	output int   letters_seen,
	output int   out_of_range_seen
);
	import i2r_pkg::*;

	localparam int NumSteps   = 13;
	localparam int MaxLetters = 15;

	typedef struct packed {
		logic [SymbolW-1:0] symbol;
		logic               last;
		logic               invalid;
	} letter_t;

	// Greedy subtraction table, largest step first
	localparam int unsigned StepWeight [NumSteps] = '{
		1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
	};
	localparam logic [SymbolW-1:0] LeadLetter [NumSteps] = '{
		"M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"
	};
	localparam logic [SymbolW-1:0] TrailLetter [NumSteps] = '{
		SymNone, "M", SymNone, "D", SymNone, "C", SymNone, "L",
		SymNone, "X", SymNone, "V", SymNone
	};

	letter_t expected_letters[$];

	// Expand one value into its expected letter run
	function automatic void predict_numeral(input logic [ValueW-1:0] v);
		int unsigned  rest;
		int           count;
		logic [SymbolW-1:0] run [MaxLetters];
		letter_t      e;
		rest  = v;
		count = 0;
		if (v == '0 || v > TopValue) begin
			e.symbol  = SymNone;
			e.last    = 1'b1;
			e.invalid = 1'b1;
			expected_letters.push_back(e);
			out_of_range_seen++;
			return;
		end
		for (int k = 0; k < NumSteps; k++) begin
			while (rest >= StepWeight[k]) begin
				if (count < MaxLetters) begin
					run[count] = LeadLetter[k];
					count++;
				end
				if (TrailLetter[k] != SymNone && count < MaxLetters) begin
					run[count] = TrailLetter[k];
					count++;
				end
				rest -= StepWeight[k];
			end
		end
		for (int k = 0; k < count; k++) begin
			e.symbol  = run[k];
			e.last    = (k == count - 1);
			e.invalid = 1'b0;
			expected_letters.push_back(e);
		end
	endfunction

	initial begin
		mismatches        = 0;
		outstanding       = 0;
		values_seen       = 0;
		letters_seen      = 0;
		out_of_range_seen = 0;
	end

	// Queue expectations on value transactions, check letter transactions
	always @(posedge clk) begin
		letter_t e;
		if (arst_n) begin
			if (num.valid && num.ready) begin
				predict_numeral(num.value);
				values_seen++;
			end
			if (chars.valid && chars.ready) begin
				letters_seen++;
				if (expected_letters.size() == 0) begin
					$display("%0t: unexpected letter symbol=%h last=%b invalid=%b",
						$time, chars.symbol, chars.last, chars.invalid);
					mismatches++;
				end else begin
					e = expected_letters.pop_front();
					if (chars.symbol !== e.symbol) begin
						$display("%0t: symbol mismatch, expected %h got %h",
							$time, e.symbol, chars.symbol);
						mismatches++;
					end
					if (chars.last !== e.last) begin
						$display("%0t: last mismatch, expected %b got %b",
							$time, e.last, chars.last);
						mismatches++;
					end
					if (chars.invalid !== e.invalid) begin
						$display("%0t: invalid mismatch, expected %b got %b",
							$time, e.invalid, chars.invalid);
						mismatches++;
					end
				end
			end
			outstanding = expected_letters.size();
		end
	end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the integer to Roman numeral converter
// Drives directed edge values, then random values with random gaps on the
// value side and random stalls on the letter side; the checker module does
// all prediction and comparison, this top reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import i2r_pkg::*;

	localparam int IdleLimit   = 2000;
	localparam int RandomCount = 340;
	localparam int DrainCycles = 32;

	logic clk = 1'b0;
	logic arst_n;

	int mismatches;
	int outstanding;
	int values_seen;
	int letters_seen;
	int out_of_range_seen;
	int idle_cycles;

	i2r_value_if num_ch();
	i2r_char_if  char_ch();

	integer_to_roman_numeral DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.num   (num_ch),
		.chars (char_ch)
	);

	roman_letter_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.num              (num_ch),
		.chars            (char_ch),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.values_seen      (values_seen),
		.letters_seen     (letters_seen),
		.out_of_range_seen(out_of_range_seen)
	);

	always #10 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Present one value at a falling edge and hold it until accepted
	task automatic send_value(input logic [ValueW-1:0] v, input bit allow_gap);
		int gap;
		gap = allow_gap ? pick_gap() : 0;
		if (gap > 0) begin
			num_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		num_ch.valid <= 1'b1;
		num_ch.value <= v;
		do @(posedge clk); while (!num_ch.ready);
		@(negedge clk);
	endtask

	// Pick a random value, mostly in range, with the edges well represented
	function automatic logic [ValueW-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return ValueW'($urandom_range(1, 3999));
		end else if (r < 80) begin
			return ValueW'($urandom_range(1, 30));
		end else if (r < 88) begin
			return ValueW'($urandom_range(3000, 3999));
		end else if (r < 95) begin
			return ValueW'($urandom_range(4000, 4095));
		end else if (r < 97) begin
			return '0;
		end
		return ValueW'($urandom_range(0, 4095));
	endfunction

	// Stall the letter side at random, with steady stretches in between
	initial begin
		int hold;
		int round;
		char_ch.ready = 1'b0;
		round = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = (round % 200 < 50) ? 0 : pick_gap();
			if (hold > 0) begin
				char_ch.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			char_ch.ready <= 1'b1;
			@(negedge clk);
			round++;
		end
	end

	// Stop the run when no transaction happens for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((num_ch.valid && num_ch.ready) || (char_ch.valid && char_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("%0t: no transaction for %0d cycles", $time, IdleLimit);
			$display("integer_to_roman_numeral regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Reset, directed values, random values, drain, verdict
	initial begin
		logic [ValueW-1:0] directed [$];
		num_ch.valid = 1'b0;
		num_ch.value = '0;
		arst_n       = 1'b0;
		directed = '{
			12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888,
			12'd4, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900,
			12'd5, 12'd10, 12'd50, 12'd100, 12'd500, 12'd1000,
			12'd3, 12'd8, 12'd1994, 12'd2444, 12'd2730, 12'd1365
		};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_value(directed[i], 1'b0);
		end
		for (int i = 0; i < RandomCount; i++) begin
			send_value(pick_value(), ((i / 40) % 4) != 3);
		end
		num_ch.valid <= 1'b0;

		// Wait out the remaining letters, then watch for strays
		while (outstanding != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Converted %0d values (%0d out of range) into %0d checked letters,",
			values_seen, out_of_range_seen, letters_seen);
		$display("with random gaps and stalls on both channels; %0d mismatches.",
			mismatches);
		if (mismatches == 0) begin
			$display("integer_to_roman_numeral regression: pass");
		end else begin
			$display("integer_to_roman_numeral regression: fail");
		end
		$finish;
	end

endmodule
